// ===== rtl/rfid_frame_decoder_unit_assert.svh =====
// -----------------------------------------------------------------------------
// rfid frame decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// -----------------------------------------------------------------------------
`ifndef RFID_FRAME_DECODER_UNIT_ASSERT_SVH
`define RFID_FRAME_DECODER_UNIT_ASSERT_SVH

// condition that holds at every edge out of reset
`define RFD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define RFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequence that holds in the same cycle as the antecedent
`define RFD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/rfd_pkg.sv =====
// -----------------------------------------------------------------------------
// rfd_pkg
// types and constants of the reader frame decoder
// -----------------------------------------------------------------------------
package rfd_pkg;

   // operation codes
   localparam logic [1:0] OP_DATA    = 2'd0;
   localparam logic [1:0] OP_ARM     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // status codes
   localparam logic [2:0] ST_BUSY   = 3'd0;
   localparam logic [2:0] ST_PREFIX = 3'd1;
   localparam logic [2:0] ST_CKSUM  = 3'd2;
   localparam logic [2:0] ST_REPEAT = 3'd3;
   localparam logic [2:0] ST_NEW    = 3'd4;

   // frame positions
   localparam logic [3:0] LAST_PREFIX = 4'd4;
   localparam logic [3:0] LAST_ID     = 4'd12;
   localparam logic [3:0] CKSUM_IDX   = 4'd13;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] transponder_id;
      logic [7:0]  received_checksum;
      logic [7:0]  computed_checksum;
   } rsp_type;

   // expected prefix byte at frame positions 0 to 4
   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      logic [7:0] value;
      case (idx)
         3'd0:    value = 8'h0E;
         3'd2:    value = 8'h11;
         3'd4:    value = 8'h05;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/rfd_frame_core.sv =====
// -----------------------------------------------------------------------------
// rfd_frame_core
// frame state and single-pass decode of one beat into one result
// -----------------------------------------------------------------------------
`include "rfid_frame_decoder_unit_assert.svh"

module rfd_frame_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  rfd_pkg::req_type item,
   output rfd_pkg::rsp_type result
);

   logic [3:0]  frame_index_ff, frame_index_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [63:0] id_bytes_ff, id_bytes_in;
   logic [63:0] last_id_ff, last_id_in;
   logic        last_valid_ff, last_valid_in;
   logic        armed_ff, armed_in;
   logic [7:0]  xor_base;

   always_comb begin
      frame_index_in = frame_index_ff;
      running_xor_in = running_xor_ff;
      id_bytes_in    = id_bytes_ff;
      last_id_in     = last_id_ff;
      last_valid_in  = last_valid_ff;
      armed_in       = armed_ff;
      result         = '0;
      result.status  = rfd_pkg::ST_BUSY;
      xor_base       = (frame_index_ff == 4'd0) ? 8'h00 : running_xor_ff;
      unique case (item.operation)
         rfd_pkg::OP_ARM: begin
            armed_in = 1'b1;
         end
         rfd_pkg::OP_RESTART: begin
            frame_index_in = 4'd0;
         end
         rfd_pkg::OP_DATA: begin
            if (frame_index_ff <= rfd_pkg::LAST_PREFIX) begin
               running_xor_in = xor_base;
               if (item.data_byte != rfd_pkg::prefix_byte(frame_index_ff[2:0])) begin
                  frame_index_in = 4'd0;
                  result.status  = rfd_pkg::ST_PREFIX;
               end else begin
                  running_xor_in = xor_base ^ item.data_byte;
                  frame_index_in = frame_index_ff + 4'd1;
               end
            end else if (frame_index_ff <= rfd_pkg::LAST_ID) begin
               running_xor_in = running_xor_ff ^ item.data_byte;
               id_bytes_in    = {item.data_byte, id_bytes_ff[63:8]};
               frame_index_in = frame_index_ff + 4'd1;
            end else if (frame_index_ff == rfd_pkg::CKSUM_IDX) begin
               frame_index_in = 4'd0;
               if (item.data_byte != running_xor_ff) begin
                  result.status            = rfd_pkg::ST_CKSUM;
                  result.received_checksum = item.data_byte;
                  result.computed_checksum = running_xor_ff;
               end else if (armed_ff || !last_valid_ff || id_bytes_ff != last_id_ff) begin
                  armed_in              = 1'b0;
                  last_valid_in         = 1'b1;
                  last_id_in            = id_bytes_ff;
                  result.status         = rfd_pkg::ST_NEW;
                  result.transponder_id = id_bytes_ff;
               end else begin
                  result.status         = rfd_pkg::ST_REPEAT;
                  result.transponder_id = id_bytes_ff;
               end
            end else begin
               frame_index_in = 4'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_index_ff <= 4'd0;
         running_xor_ff <= 8'h00;
         last_id_ff     <= 64'd0;
         last_valid_ff  <= 1'b0;
         armed_ff       <= 1'b1;
      end else if (advance) begin
         frame_index_ff <= frame_index_in;
         running_xor_ff <= running_xor_in;
         last_id_ff     <= last_id_in;
         last_valid_ff  <= last_valid_in;
         armed_ff       <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         id_bytes_ff <= id_bytes_in;
      end
   end

   `RFD_ASSERT_ALWAYS(a_index_range, clock, reset, frame_index_ff <= rfd_pkg::CKSUM_IDX,
      "frame index beyond checksum position")
   `RFD_ASSERT_NEXT(a_report_disarms, clock, reset,
      advance && result.status == rfd_pkg::ST_NEW,
      !armed_ff && last_valid_ff && last_id_ff == $past(id_bytes_ff),
      "report did not update last id and flag")
   `RFD_ASSERT_NEXT(a_arm_sets, clock, reset,
      advance && item.operation == rfd_pkg::OP_ARM, armed_ff,
      "arm command did not set flag")
   `RFD_ASSERT_SAME(a_repeat_needs_last, clock, reset,
      advance && result.status == rfd_pkg::ST_REPEAT, last_valid_ff && !armed_ff,
      "repeat suppressed without prior report")

endmodule

// ===== rtl/rfd_result_reg.sv =====
// -----------------------------------------------------------------------------
// rfd_result_reg
// result register holding one beat towards the response channel
// -----------------------------------------------------------------------------
module rfd_result_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  rfd_pkg::rsp_type result,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rfd_pkg::rsp_type rsp_payload,
   output logic             full
);

   logic             valid_ff, valid_in;
   rfd_pkg::rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;
   assign full        = valid_ff && rsp_stall;

endmodule

// ===== rtl/rfid_frame_decoder_unit.sv =====
// -----------------------------------------------------------------------------
// rfid_frame_decoder_unit
// decoder for 14-byte reader frames: prefix check, xor checksum, id report
// -----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  rfd_pkg::req_type
//  rsp      out        rsp_valid / rsp_stall  rfd_pkg::rsp_type
//
//  one beat per cycle sustained while rsp_stall is low; one response beat for every request beat
//  a beat passes the input register, then is decoded into the result register
//  synchronous reset clears the frame index and arms the new-run flag
//  req_stall rises only when both registers hold a beat and rsp_stall is high
// -----------------------------------------------------------------------------
`include "rfid_frame_decoder_unit_assert.svh"

module rfid_frame_decoder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rfd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rfd_pkg::rsp_type rsp_payload
);

   logic             in_valid_ff, in_valid_in;
   rfd_pkg::req_type in_item_ff;
   rfd_pkg::rsp_type result;
   logic             move;
   logic             out_full;
   logic             req_take;

   assign move      = in_valid_ff && !out_full;
   assign req_stall = in_valid_ff && out_full;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
   end

   rfd_frame_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (move),
      .item    (in_item_ff),
      .result  (result)
   );

   rfd_result_reg u_result (
      .clock       (clock),
      .reset       (reset),
      .load        (move),
      .result      (result),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .full        (out_full)
   );

   `RFD_ASSERT_NEXT(a_held_beat_kept, clock, reset, in_valid_ff && out_full,
      in_valid_ff && $stable(in_item_ff), "held request beat lost")
   `RFD_ASSERT_NEXT(a_move_fills_out, clock, reset, move, rsp_valid,
      "decoded beat missing at response")
   `RFD_ASSERT_SAME(a_stall_only_full, clock, reset, req_stall, rsp_valid && rsp_stall,
      "request stalled while result register free")

endmodule
